/* sv/m3mt_pkg.sv */
// Shared types, codes and constants for the 3x3 matrix multiply/transpose block.
// Used by every module of the block except m3mt_ram; depends on nothing else.
package m3mt_pkg;

   // default arithmetic configuration
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field and matrix geometry
   localparam int FIELD_W   = 32;
   localparam int INDEX_W   = 4;
   localparam int NDIM      = 3;
   localparam int NELEM     = NDIM * NDIM;
   localparam int ADDR_W    = $clog2(NELEM);
   localparam int CNT_W     = 2;
   localparam int TDATA_W   = 40;
   localparam int TUSER_W   = 2;

   // item kinds carried on req_tuser
   typedef enum logic [1:0] {
      ACT_LOAD_A = 2'd0,
      ACT_LOAD_B = 2'd1,
      ACT_MUL    = 2'd2,
      ACT_XPOSE  = 2'd3
   } action_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT
   } state_type;

   // one memory read issued by the sequencer
   typedef struct packed {
      logic rd_vld;
      logic first;
      logic last;
      logic xpose;
   } issue_type;

   // tag of the result element under work
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               last;
   } elem_type;

   // stored element width: loads carry at most FIELD_W bits
   function automatic int elem_width(input int dw);
      return (dw < FIELD_W) ? dw : FIELD_W;
   endfunction

endpackage

/* sv/m3mt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module m3mt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* sv/m3mt_seq.sv */
// Sequencer: takes input transfers, writes loads into the matrix memories and
// walks the nine result elements, issuing reads. Depends on m3mt_pkg.
module m3mt_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [m3mt_pkg::TUSER_W-1:0]  req_action,
   input  logic [m3mt_pkg::INDEX_W-1:0]  req_index,
   output logic                          a_wr_en,
   output logic                          b_wr_en,
   output logic [m3mt_pkg::ADDR_W-1:0]   wr_addr,
   output logic [m3mt_pkg::ADDR_W-1:0]   a_rd_addr,
   output logic [m3mt_pkg::ADDR_W-1:0]   b_rd_addr,
   output m3mt_pkg::issue_type           issue,
   output m3mt_pkg::elem_type            elem,
   input  logic                          elem_load
);

   localparam logic [m3mt_pkg::CNT_W-1:0]  LAST_CNT = m3mt_pkg::CNT_W'(m3mt_pkg::NDIM - 1);
   localparam logic [m3mt_pkg::ADDR_W-1:0] DIM_A    = m3mt_pkg::ADDR_W'(m3mt_pkg::NDIM);
   localparam logic [m3mt_pkg::INDEX_W-1:0] LAST_POS =
      m3mt_pkg::INDEX_W'(m3mt_pkg::NELEM - 1);
   localparam logic [m3mt_pkg::INDEX_W-1:0] MAX_IDX  = LAST_POS;

   m3mt_pkg::state_type        state_ff, state_in;
   m3mt_pkg::action_type       action;
   logic [m3mt_pkg::CNT_W-1:0] col_ff, row_ff, k_ff;
   logic                       xpose_ff;
   logic                       accept;
   logic                       start;
   logic                       load_ok;
   logic                       last_k;
   logic [m3mt_pkg::INDEX_W-1:0] pos;

   assign action  = m3mt_pkg::action_type'(req_action);
   assign accept  = req_tvalid && req_tready;
   assign start   = accept && (action inside {m3mt_pkg::ACT_MUL, m3mt_pkg::ACT_XPOSE});
   assign load_ok = accept && (action inside {m3mt_pkg::ACT_LOAD_A, m3mt_pkg::ACT_LOAD_B})
                    && (req_index <= MAX_IDX);
   assign last_k  = xpose_ff || (k_ff == LAST_CNT);
   assign pos     = m3mt_pkg::INDEX_W'(m3mt_pkg::ADDR_W'(col_ff) * DIM_A
                                       + m3mt_pkg::ADDR_W'(row_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         m3mt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = m3mt_pkg::ST_READ;
            end
         end
         m3mt_pkg::ST_READ: begin
            if (last_k) begin
               state_in = m3mt_pkg::ST_WAIT;
            end
         end
         m3mt_pkg::ST_WAIT: begin
            if (elem_load) begin
               state_in = (pos == LAST_POS) ? m3mt_pkg::ST_IDLE : m3mt_pkg::ST_READ;
            end
         end
         default: state_in = m3mt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = (state_ff == m3mt_pkg::ST_IDLE);
      a_wr_en      = load_ok && (action == m3mt_pkg::ACT_LOAD_A);
      b_wr_en      = load_ok && (action == m3mt_pkg::ACT_LOAD_B);
      wr_addr      = m3mt_pkg::ADDR_W'(req_index);
      issue.rd_vld = (state_ff == m3mt_pkg::ST_READ);
      issue.first  = (k_ff == '0);
      issue.last   = last_k;
      issue.xpose  = xpose_ff;
      elem.index   = pos;
      elem.last    = (pos == LAST_POS);
      // transpose reads A at row*3+col; multiply reads A at k*3+row, B at col*3+k
      if (xpose_ff) begin
         a_rd_addr = m3mt_pkg::ADDR_W'(row_ff) * DIM_A + m3mt_pkg::ADDR_W'(col_ff);
      end else begin
         a_rd_addr = m3mt_pkg::ADDR_W'(k_ff) * DIM_A + m3mt_pkg::ADDR_W'(row_ff);
      end
      b_rd_addr = m3mt_pkg::ADDR_W'(col_ff) * DIM_A + m3mt_pkg::ADDR_W'(k_ff);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m3mt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // element and term counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         k_ff     <= '0;
         xpose_ff <= 1'b0;
      end else begin
         case (state_ff)
            m3mt_pkg::ST_IDLE: begin
               if (start) begin
                  col_ff   <= '0;
                  row_ff   <= '0;
                  k_ff     <= '0;
                  xpose_ff <= (action == m3mt_pkg::ACT_XPOSE);
               end
            end
            m3mt_pkg::ST_READ: begin
               if (!last_k) begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            m3mt_pkg::ST_WAIT: begin
               // advance to the next element in column-major order
               if (elem_load) begin
                  k_ff <= '0;
                  if (row_ff == LAST_CNT) begin
                     row_ff <= '0;
                     col_ff <= col_ff + 1'b1;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                  end
               end
            end
            default: begin
               k_ff <= '0;
            end
         endcase
      end
   end

   // an element leaves the datapath only while the sequencer waits for it
   a_load_in_wait: assert property (@(posedge clock) disable iff (reset)
      elem_load |-> (state_ff == m3mt_pkg::ST_WAIT))
      else $error("element loaded outside wait state");

   // no memory write while a read sequence is running
   a_no_wr_in_run: assert property (@(posedge clock) disable iff (reset)
      (a_wr_en || b_wr_en) |-> (state_ff == m3mt_pkg::ST_IDLE))
      else $error("memory write during read sequence");

   // the final read of an element is followed by no read until it is loaded
   a_one_elem: assert property (@(posedge clock) disable iff (reset)
      (issue.rd_vld && issue.last) |=> !issue.rd_vld)
      else $error("read issued before element completed");

endmodule

/* sv/m3mt_datapath.sv */
// Datapath: multiply stage, accumulator, shift and saturation, and the result
// output register. Depends on m3mt_pkg.
module m3mt_datapath #(
   parameter int DATA_WIDTH = m3mt_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = m3mt_pkg::FRAC_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  m3mt_pkg::issue_type                          issue,
   input  m3mt_pkg::elem_type                           elem,
   input  logic signed [m3mt_pkg::elem_width(DATA_WIDTH)-1:0] a_rd_data,
   input  logic signed [m3mt_pkg::elem_width(DATA_WIDTH)-1:0] b_rd_data,
   output logic                                         elem_load,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [m3mt_pkg::INDEX_W-1:0]                 rsp_index,
   output logic [m3mt_pkg::FIELD_W-1:0]                 rsp_value,
   output logic                                         rsp_last
);

   localparam int ELEM_W = m3mt_pkg::elem_width(DATA_WIDTH);
   localparam int PROD_W = 2 * ELEM_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int EXT_W  = ACC_W + m3mt_pkg::FIELD_W;
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   // stage flags
   logic s1_vld_ff, s1_first_ff, s1_last_ff, s1_xpose_ff;
   logic s2_vld_ff, s2_first_ff, s2_last_ff, s2_xpose_ff;
   logic done_ff, s3_xpose_ff;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted, sat, val;
   logic signed [EXT_W-1:0]  ext;
   logic                     rsp_vld_ff, rsp_vld_in;

   // align control with the registered memory read, then with the product
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue.rd_vld;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_first_ff <= issue.first;
      s1_last_ff  <= issue.last;
      s1_xpose_ff <= issue.xpose;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_xpose_ff <= s1_xpose_ff;
   end

   // multiply, or pass the A element for a transpose
   assign prod_in = s1_xpose_ff ? PROD_W'(a_rd_data) : a_rd_data * b_rd_data;

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   // accumulate the three terms of a dot product; a transpose element is a single term
   assign acc_in = s2_first_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (s2_vld_ff && s2_last_ff) begin
         s3_xpose_ff <= s2_xpose_ff;
      end
   end

   // hold a finished element until the output register takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (s2_vld_ff && s2_last_ff) begin
         done_ff <= 1'b1;
      end else if (elem_load) begin
         done_ff <= 1'b0;
      end
   end

   // floor shift and saturate to DATA_WIDTH; a transposed element passes as is
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      if (shifted > SAT_MAX) begin
         sat = SAT_MAX;
      end else if (shifted < SAT_MIN) begin
         sat = SAT_MIN;
      end else begin
         sat = shifted;
      end
      val = s3_xpose_ff ? acc_ff : sat;
      ext = EXT_W'(val);
   end

   // output register
   assign elem_load  = done_ff && (!rsp_vld_ff || rsp_tready);
   assign rsp_vld_in = elem_load || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (elem_load) begin
         rsp_value <= ext[m3mt_pkg::FIELD_W-1:0];
         rsp_index <= elem.index;
         rsp_last  <= elem.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;

   // a new element starts only after the previous one has left the accumulator
   a_first_clear: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && s2_first_ff) |-> !done_ff)
      else $error("accumulator overwritten before element taken");

   // the output becomes valid only from a finished element
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(done_ff))
      else $error("result valid without finished element");

   // every read in the first stage moves on to the second stage and the accumulator
   a_pipe_flow: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |=> s2_vld_ff)
      else $error("read lost in pipeline");

endmodule

/* sv/mat3_multiply_transpose.sv */
// Top level of the 3x3 fixed-point matrix multiply and transpose block.
// Depends on m3mt_pkg, m3mt_ram, m3mt_seq and m3mt_datapath.
//
// Two 3x3 matrices A and B live in two small memories, column-major
// (index = column*3+row), and are loaded one element per input transfer
// (tuser 0 loads A, 1 loads B; an index above 8 is dropped). A multiply transfer
// (tuser 2) returns the nine elements of A*B in index order, each a dot product
// summed exactly, floor-shifted right by FRAC_BITS and saturated to a signed
// DATA_WIDTH value; a transpose transfer (tuser 3) returns A transposed. The ninth
// result carries tlast. Each multiply element takes three reads through the single
// read port of each memory into one shared multiplier, then passes the read,
// multiply and accumulate stages; a transpose element takes one read of A. The
// reads of the next element start only once the previous element has entered the
// output register, so a stalled output holds the sequence. The next input
// transfer is taken once the ninth result sits in the output register. Reading an
// element that was never loaded returns an undefined value.
module mat3_multiply_transpose #(
   parameter int DATA_WIDTH = m3mt_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = m3mt_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [3:0] element_index, [35:4] element_value, [39:36] zero
   input  logic [m3mt_pkg::TDATA_W-1:0]  req_tdata,
   // [1:0] action
   input  logic [m3mt_pkg::TUSER_W-1:0]  req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [3:0] result_index, [35:4] result_value, [39:36] zero
   output logic [m3mt_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int ELEM_W = m3mt_pkg::elem_width(DATA_WIDTH);
   localparam int VAL_LO = m3mt_pkg::INDEX_W;
   localparam int PAD_W  = m3mt_pkg::TDATA_W - m3mt_pkg::INDEX_W - m3mt_pkg::FIELD_W;

   logic                          a_wr_en, b_wr_en;
   logic [m3mt_pkg::ADDR_W-1:0]   wr_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_W-1:0]             wr_data, a_rd_data, b_rd_data;
   m3mt_pkg::issue_type           issue;
   m3mt_pkg::elem_type            elem;
   logic                          elem_load;
   logic [m3mt_pkg::INDEX_W-1:0]  rsp_index;
   logic [m3mt_pkg::FIELD_W-1:0]  rsp_value;

   // keep the low element bits of a loaded value
   assign wr_data = req_tdata[VAL_LO +: ELEM_W];

   m3mt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_index  (req_tdata[m3mt_pkg::INDEX_W-1:0]),
      .a_wr_en    (a_wr_en),
      .b_wr_en    (b_wr_en),
      .wr_addr    (wr_addr),
      .a_rd_addr  (a_rd_addr),
      .b_rd_addr  (b_rd_addr),
      .issue      (issue),
      .elem       (elem),
      .elem_load  (elem_load)
   );

   m3mt_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (m3mt_pkg::NELEM)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue.rd_vld),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   m3mt_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (m3mt_pkg::NELEM)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue.rd_vld),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   m3mt_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .elem       (elem),
      .a_rd_data  (a_rd_data),
      .b_rd_data  (b_rd_data),
      .elem_load  (elem_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_index  (rsp_index),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   // pack the result transfer
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_value, rsp_index};

endmodule
